@@ rtl/priority_interrupt_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority interrupt controller
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH

// condition implies property in the same cycle
`define PIC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition implies property in the next cycle
`define PIC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority interrupt controller package
// Command, init step and end-of-interrupt codes, plus the rotating priority
// encoders shared by the controller.
// ----------------------------------------------------------------------------
package pic_pkg;

  typedef enum logic [1:0] {
    CMD_LEVEL = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    INIT_DONE = 2'd0,
    INIT_ICW2 = 2'd1,
    INIT_ICW3 = 2'd2,
    INIT_ICW4 = 2'd3
  } init_step_t;

  typedef enum logic [2:0] {
    OP_AEOI_ROTATE_CLEAR = 3'd0,
    OP_EOI               = 3'd1,
    OP_NOP               = 3'd2,
    OP_SPECIFIC_EOI      = 3'd3,
    OP_AEOI_ROTATE_SET   = 3'd4,
    OP_ROTATE_EOI        = 3'd5,
    OP_SET_PRIORITY      = 3'd6,
    OP_ROTATE_SPECIFIC   = 3'd7
  } ocw2_op_t;

  localparam logic PORT_COMMAND = 1'b0;
  localparam logic PORT_DATA    = 1'b1;

  localparam logic CFG_LEVEL_TRIGGER = 1'b0;
  localparam logic CFG_IS_MASTER     = 1'b1;

  localparam int BIT_ICW1     = 4;
  localparam int BIT_OCW3     = 3;
  localparam int BIT_POLL     = 2;
  localparam int BIT_READ_REG = 1;
  localparam int BIT_SMM_SET  = 6;
  localparam int BIT_SMM_VAL  = 5;
  localparam int BIT_LTIM     = 3;
  localparam int BIT_SNGL     = 1;
  localparam int BIT_IC4      = 0;
  localparam int BIT_SFNM     = 4;
  localparam int BIT_AEOI     = 1;

  localparam logic [7:0] SLAVE_LINE_BIT = 8'h04;
  localparam logic [7:0] POLL_FLAG      = 8'h80;
  localparam logic [3:0] NO_LINE        = 4'd8;

  function automatic logic [3:0] best_rank(input logic [7:0] bits,
                                           input logic [2:0] base);
    logic [15:0] dbl;
    logic [7:0]  rot;
    logic [3:0]  r;
    dbl = {bits, bits} >> base;
    rot = dbl[7:0];
    r   = NO_LINE;
    for (int i = 7; i >= 0; i--) begin
      if (rot[i]) begin
        r = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [3:0] pending_line(input logic [7:0] req,
                                              input logic [7:0] mask,
                                              input logic [7:0] svc,
                                              input logic [2:0] base,
                                              input logic       smm,
                                              input logic       nested);
    logic [7:0] cur;
    logic [3:0] want;
    logic [3:0] held;
    logic [3:0] ln;
    want = best_rank(req & ~mask, base);
    cur  = svc;
    if (smm) begin
      cur = cur & ~mask;
    end
    if (nested) begin
      cur = cur & ~SLAVE_LINE_BIT;
    end
    held = best_rank(cur, base);
    ln   = NO_LINE;
    if (want != NO_LINE && want < held) begin
      ln = {1'b0, want[2:0] + base};
    end
    return ln;
  endfunction

endpackage

@@ rtl/priority_interrupt_controller.sv @@
// ----------------------------------------------------------------------------
// Priority interrupt controller
// Each item moves from the input register into the result register, and
// waits in the input register while the result register is stalled.
// Throughput: one item per cycle unless result_stall holds, set by the single
// state update between the two registers. Synchronous active-high reset
// clears both stages, all controller state and the configuration registers.
// ----------------------------------------------------------------------------
`include "priority_interrupt_controller_defines.svh"

module priority_interrupt_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] cmd,
  input  logic [2:0] line,
  input  logic       level,
  input  logic       port_addr,
  input  logic [7:0] write_data,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data,
  output logic [7:0] vector,
  output logic       int_request,
  output logic       unsupported
);

  logic [7:0] level_trigger_mask;
  logic       is_master;

  logic       busy;
  logic [1:0] cmd_q;
  logic [2:0] line_q;
  logic       level_q;
  logic       addr_q;
  logic [7:0] data_q;
  logic       advance;

  logic [7:0] line_last_level, line_last_level_next;
  logic [7:0] request_bits, request_bits_next;
  logic [7:0] mask_bits, mask_bits_next;
  logic [7:0] service_bits, service_bits_next;
  logic [2:0] priority_base, priority_base_next;
  logic [4:0] vector_base, vector_base_next;
  logic       read_service_select, read_service_select_next;
  logic       poll_pending, poll_pending_next;
  logic       special_mask_mode, special_mask_mode_next;
  pic_pkg::init_step_t init_step, init_step_next;
  logic       auto_end_mode, auto_end_mode_next;
  logic       rotate_on_auto_end, rotate_on_auto_end_next;
  logic       fully_nested_mode, fully_nested_mode_next;
  logic       fourth_word_needed, fourth_word_needed_next;
  logic       single_controller, single_controller_next;

  logic [7:0] rd_next;
  logic [7:0] vec_next;
  logic       flag_next;
  logic       int_next;
  logic [3:0] pend_now;
  logic       take;
  logic [2:0] take_ln;
  logic [7:0] take_bit;
  logic [7:0] line_bit;
  logic [3:0] eoi_rank;
  logic [2:0] eoi_ln;

  assign advance    = busy && (!result_valid || !result_stall);
  assign item_stall = busy && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_trigger_mask <= 8'h00;
      is_master          <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pic_pkg::CFG_LEVEL_TRIGGER: level_trigger_mask <= cfg_data;
        pic_pkg::CFG_IS_MASTER:     is_master          <= cfg_data[0];
        default:                    is_master          <= is_master;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!item_stall) begin
      busy <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      cmd_q   <= cmd;
      line_q  <= line;
      level_q <= level;
      addr_q  <= port_addr;
      data_q  <= write_data;
    end
  end

  assign pend_now = pic_pkg::pending_line(request_bits, mask_bits, service_bits,
                                          priority_base, special_mask_mode,
                                          fully_nested_mode && is_master);
  assign line_bit = 8'h01 << line_q;
  assign eoi_rank = pic_pkg::best_rank(service_bits, priority_base);
  assign eoi_ln   = eoi_rank[2:0] + priority_base;
  assign take_ln  = pend_now[2:0];
  assign take_bit = 8'h01 << take_ln;

  always_comb begin
    line_last_level_next     = line_last_level;
    request_bits_next        = request_bits;
    mask_bits_next           = mask_bits;
    service_bits_next        = service_bits;
    priority_base_next       = priority_base;
    vector_base_next         = vector_base;
    read_service_select_next = read_service_select;
    poll_pending_next        = poll_pending;
    special_mask_mode_next   = special_mask_mode;
    init_step_next           = init_step;
    auto_end_mode_next       = auto_end_mode;
    rotate_on_auto_end_next  = rotate_on_auto_end;
    fully_nested_mode_next   = fully_nested_mode;
    fourth_word_needed_next  = fourth_word_needed;
    single_controller_next   = single_controller;
    rd_next   = 8'h00;
    vec_next  = 8'h00;
    flag_next = 1'b0;
    take      = 1'b0;

    unique case (pic_pkg::cmd_t'(cmd_q))
      pic_pkg::CMD_LEVEL: begin
        if (level_q) begin
          if ((level_trigger_mask & line_bit) != 8'h00 ||
              (line_last_level & line_bit) == 8'h00) begin
            request_bits_next = request_bits | line_bit;
          end
          line_last_level_next = line_last_level | line_bit;
        end else begin
          if ((level_trigger_mask & line_bit) != 8'h00) begin
            request_bits_next = request_bits & ~line_bit;
          end
          line_last_level_next = line_last_level & ~line_bit;
        end
      end
      pic_pkg::CMD_WRITE: begin
        if (addr_q == pic_pkg::PORT_COMMAND) begin
          priority if (data_q[pic_pkg::BIT_ICW1]) begin
            line_last_level_next     = 8'h00;
            request_bits_next        = 8'h00;
            mask_bits_next           = 8'h00;
            service_bits_next        = 8'h00;
            priority_base_next       = 3'd0;
            vector_base_next         = 5'd0;
            read_service_select_next = 1'b0;
            poll_pending_next        = 1'b0;
            special_mask_mode_next   = 1'b0;
            init_step_next           = pic_pkg::INIT_ICW2;
            auto_end_mode_next       = 1'b0;
            rotate_on_auto_end_next  = 1'b0;
            fully_nested_mode_next   = 1'b0;
            fourth_word_needed_next  = data_q[pic_pkg::BIT_IC4];
            single_controller_next   = data_q[pic_pkg::BIT_SNGL];
            flag_next                = data_q[pic_pkg::BIT_LTIM];
          end else if (data_q[pic_pkg::BIT_OCW3]) begin
            if (data_q[pic_pkg::BIT_POLL]) begin
              poll_pending_next = 1'b1;
            end
            if (data_q[pic_pkg::BIT_READ_REG]) begin
              read_service_select_next = data_q[0];
            end
            if (data_q[pic_pkg::BIT_SMM_SET]) begin
              special_mask_mode_next = data_q[pic_pkg::BIT_SMM_VAL];
            end
          end else begin
            unique case (pic_pkg::ocw2_op_t'(data_q[7:5]))
              pic_pkg::OP_AEOI_ROTATE_CLEAR: rotate_on_auto_end_next = 1'b0;
              pic_pkg::OP_AEOI_ROTATE_SET:   rotate_on_auto_end_next = 1'b1;
              pic_pkg::OP_EOI: begin
                if (eoi_rank != pic_pkg::NO_LINE) begin
                  service_bits_next = service_bits & ~(8'h01 << eoi_ln);
                end
              end
              pic_pkg::OP_ROTATE_EOI: begin
                if (eoi_rank != pic_pkg::NO_LINE) begin
                  service_bits_next  = service_bits & ~(8'h01 << eoi_ln);
                  priority_base_next = eoi_ln + 3'd1;
                end
              end
              pic_pkg::OP_SPECIFIC_EOI: begin
                service_bits_next = service_bits & ~(8'h01 << data_q[2:0]);
              end
              pic_pkg::OP_SET_PRIORITY: begin
                priority_base_next = data_q[2:0] + 3'd1;
              end
              pic_pkg::OP_ROTATE_SPECIFIC: begin
                service_bits_next  = service_bits & ~(8'h01 << data_q[2:0]);
                priority_base_next = data_q[2:0] + 3'd1;
              end
              pic_pkg::OP_NOP: begin
                service_bits_next = service_bits;
              end
              default: begin
                service_bits_next = service_bits;
              end
            endcase
          end
        end else begin
          unique case (init_step)
            pic_pkg::INIT_DONE: mask_bits_next = data_q;
            pic_pkg::INIT_ICW2: begin
              vector_base_next = data_q[7:3];
              if (!single_controller) begin
                init_step_next = pic_pkg::INIT_ICW3;
              end else if (fourth_word_needed) begin
                init_step_next = pic_pkg::INIT_ICW4;
              end else begin
                init_step_next = pic_pkg::INIT_DONE;
              end
            end
            pic_pkg::INIT_ICW3: begin
              init_step_next = fourth_word_needed ? pic_pkg::INIT_ICW4 :
                                                    pic_pkg::INIT_DONE;
            end
            pic_pkg::INIT_ICW4: begin
              fully_nested_mode_next = data_q[pic_pkg::BIT_SFNM];
              auto_end_mode_next     = data_q[pic_pkg::BIT_AEOI];
              init_step_next         = pic_pkg::INIT_DONE;
            end
            default: init_step_next = pic_pkg::INIT_DONE;
          endcase
        end
      end
      pic_pkg::CMD_READ: begin
        if (poll_pending) begin
          poll_pending_next = 1'b0;
          if (pend_now != pic_pkg::NO_LINE) begin
            take    = 1'b1;
            rd_next = pic_pkg::POLL_FLAG | {5'd0, pend_now[2:0]};
          end
        end else if (addr_q == pic_pkg::PORT_COMMAND) begin
          rd_next = read_service_select ? service_bits : request_bits;
        end else begin
          rd_next = mask_bits;
        end
      end
      pic_pkg::CMD_ACK: begin
        if (pend_now != pic_pkg::NO_LINE) begin
          take     = 1'b1;
          vec_next = {vector_base, pend_now[2:0]};
        end else begin
          vec_next = {vector_base, 3'd7};
        end
      end
      default: begin
        rd_next = 8'h00;
      end
    endcase

    if (take) begin
      if (auto_end_mode) begin
        if (rotate_on_auto_end) begin
          priority_base_next = take_ln + 3'd1;
        end
      end else begin
        service_bits_next = service_bits | take_bit;
      end
      if ((level_trigger_mask & take_bit) == 8'h00) begin
        request_bits_next = request_bits & ~take_bit;
      end
    end

    int_next = pic_pkg::pending_line(request_bits_next, mask_bits_next,
                                     service_bits_next, priority_base_next,
                                     special_mask_mode_next,
                                     fully_nested_mode_next && is_master)
               != pic_pkg::NO_LINE;
  end

  // controller state, advanced once per transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_last_level     <= 8'h00;
      request_bits        <= 8'h00;
      mask_bits           <= 8'h00;
      service_bits        <= 8'h00;
      priority_base       <= 3'd0;
      vector_base         <= 5'd0;
      read_service_select <= 1'b0;
      poll_pending        <= 1'b0;
      special_mask_mode   <= 1'b0;
      init_step           <= pic_pkg::INIT_DONE;
      auto_end_mode       <= 1'b0;
      rotate_on_auto_end  <= 1'b0;
      fully_nested_mode   <= 1'b0;
      fourth_word_needed  <= 1'b0;
      single_controller   <= 1'b0;
    end else if (advance) begin
      line_last_level     <= line_last_level_next;
      request_bits        <= request_bits_next;
      mask_bits           <= mask_bits_next;
      service_bits        <= service_bits_next;
      priority_base       <= priority_base_next;
      vector_base         <= vector_base_next;
      read_service_select <= read_service_select_next;
      poll_pending        <= poll_pending_next;
      special_mask_mode   <= special_mask_mode_next;
      init_step           <= init_step_next;
      auto_end_mode       <= auto_end_mode_next;
      rotate_on_auto_end  <= rotate_on_auto_end_next;
      fully_nested_mode   <= fully_nested_mode_next;
      fourth_word_needed  <= fourth_word_needed_next;
      single_controller   <= single_controller_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data   <= rd_next;
      vector      <= vec_next;
      int_request <= int_next;
      unsupported <= flag_next;
    end
  end

  `PIC_ASSERT_NEXT(a_advance_fills, advance, result_valid, "result lost after transfer")
  `PIC_ASSERT_NOW(a_empty_no_stall, !busy, !item_stall, "stall with empty input register")
  `PIC_ASSERT_NOW(a_int_matches_state, result_valid,
                  int_request == (pend_now != pic_pkg::NO_LINE), "interrupt output mismatch")
  `PIC_ASSERT_NOW(a_icw1_restarts, result_valid && unsupported,
                  init_step == pic_pkg::INIT_ICW2 && service_bits == 8'h00,
                  "flagged init word did not restart init sequence")

endmodule
